@@ rtl/core/ulcd_pkg.sv @@
// Shared types and constants for the line command to duty block.
// No dependencies; the decoder, output stage, top level and testbench import this package.
package ulcd_pkg;

  localparam int unsigned MaxLine  = 15;
  localparam int unsigned CountW   = $clog2(MaxLine + 1);

  localparam logic [7:0] ChrLf     = 8'h0A;
  localparam logic [7:0] ChrCr     = 8'h0D;
  localparam logic [7:0] ChrZero   = 8'h30;
  localparam logic [7:0] ChrNine   = 8'h39;
  localparam logic [7:0] ChrO      = 8'h4F;
  localparam logic [7:0] ChrN      = 8'h4E;
  localparam logic [7:0] ChrF      = 8'h46;

  localparam logic [6:0] NumMax    = 7'd100;
  localparam logic [6:0] NumSat    = 7'd101;
  localparam logic [7:0] DutyFull  = 8'd255;
  localparam logic [7:0] DutyOff   = 8'd0;
  // ceil(255 * 2^16 / 100): value * DutyRecip >> 16 equals value * 255 / 100 for 0..100
  localparam logic [17:0] DutyRecip = 18'd167117;

  typedef enum logic [2:0] {
    WM_START = 3'd0,
    WM_O     = 3'd1,
    WM_ON    = 3'd2,
    WM_OF    = 3'd3,
    WM_OFF   = 3'd4,
    WM_NONE  = 3'd5
  } ulcd_match_e;

  typedef enum logic [1:0] {
    ACT_ON    = 2'd0,
    ACT_OFF   = 2'd1,
    ACT_LEVEL = 2'd2
  } ulcd_action_e;

  typedef struct packed {
    logic         hit;
    ulcd_action_e action;
    logic [7:0]   duty;
    logic [6:0]   percent;
  } ulcd_res_t;

endpackage

@@ rtl/core/ulcd_if.sv @@
// Valid/ready channel interfaces: received bytes in, duty commands out.
// Depends on nothing; payload widths are fixed by the channel fields.
interface ulcd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ulcd_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] duty_value;
  logic [6:0] percent_value;

  modport source (output valid, output action, output duty_value, output percent_value,
                  input ready);
  modport sink   (input valid, input action, input duty_value, input percent_value,
                  output ready);
endinterface

@@ rtl/core/ulcd_decoder.sv @@
// Line state (count, word match, digit flag, running value) and line decode.
// Depends on ulcd_pkg.
module ulcd_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  output ulcd_pkg::ulcd_res_t res_o
);
  import ulcd_pkg::*;

  logic [CountW-1:0] count_q, count_d;
  ulcd_match_e       match_q, match_d;
  logic              digits_q, digits_d;
  logic [6:0]        num_q, num_d;

  logic        is_term;
  logic        is_digit;
  logic        room;
  logic [9:0]  num_next;
  logic [24:0] prod;

  assign is_term  = (byte_i == ChrLf) || (byte_i == ChrCr);
  assign is_digit = (byte_i >= ChrZero) && (byte_i <= ChrNine);
  assign room     = (count_q < CountW'(MaxLine));
  assign num_next = 10'(num_q) * 10'd10 + 10'(byte_i - ChrZero);
  assign prod     = 25'(num_q) * 25'(DutyRecip);

  always_comb begin
    res_o = '{hit: 1'b0, action: ACT_LEVEL, duty: prod[23:16], percent: num_q};
    if (is_term && (count_q != '0)) begin
      if (match_q == WM_ON) begin
        res_o = '{hit: 1'b1, action: ACT_ON, duty: DutyFull, percent: 7'd0};
      end else if (match_q == WM_OFF) begin
        res_o = '{hit: 1'b1, action: ACT_OFF, duty: DutyOff, percent: 7'd0};
      end else if (digits_q && (num_q <= NumMax)) begin
        res_o.hit = 1'b1;
      end
    end
  end

  always_comb begin
    count_d  = count_q;
    match_d  = match_q;
    digits_d = digits_q;
    num_d    = num_q;
    if (step_i) begin
      if (is_term) begin
        if (count_q != '0) begin
          count_d  = '0;
          match_d  = WM_START;
          digits_d = 1'b1;
          num_d    = '0;
        end
      end else if (room) begin
        count_d = count_q + CountW'(1);
        case (match_q)
          WM_START: match_d = (byte_i == ChrO) ? WM_O : WM_NONE;
          WM_O: begin
            if (byte_i == ChrN) match_d = WM_ON;
            else if (byte_i == ChrF) match_d = WM_OF;
            else match_d = WM_NONE;
          end
          WM_OF:    match_d = (byte_i == ChrF) ? WM_OFF : WM_NONE;
          default:  match_d = WM_NONE;
        endcase
        if (!is_digit) begin
          digits_d = 1'b0;
        end else if (digits_q) begin
          num_d = (num_next > 10'(NumMax)) ? NumSat : num_next[6:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      match_q  <= WM_START;
      digits_q <= 1'b1;
      num_q    <= '0;
    end else begin
      count_q  <= count_d;
      match_q  <= match_d;
      digits_q <= digits_d;
      num_q    <= num_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxLine)) else $error("line count above limit");

  a_num_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    num_q <= NumSat) else $error("running value above saturation");

  a_term_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && is_term |=> (count_q == '0) && (num_q == '0) && digits_q)
    else $error("line state not cleared after terminator");

  a_word_no_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (match_q == WM_ON || match_q == WM_OFF || match_q == WM_O || match_q == WM_OF)
      |-> !digits_q) else $error("word match with digit-only line");

endmodule

@@ rtl/core/ulcd_out_stage.sv @@
// Result register driving the command channel.
// Depends on ulcd_pkg and ulcd_if.
module ulcd_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  ulcd_pkg::ulcd_res_t res_i,
  output logic                free_o,
  ulcd_cmd_if.source          cmd_o
);
  import ulcd_pkg::*;

  logic         valid_q;
  ulcd_action_e action_q;
  logic [7:0]   duty_q;
  logic [6:0]   pct_q;

  assign free_o = !valid_q || cmd_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      action_q <= res_i.action;
      duty_q   <= res_i.duty;
      pct_q    <= res_i.percent;
    end
  end

  assign cmd_o.valid         = valid_q;
  assign cmd_o.action        = action_q;
  assign cmd_o.duty_value    = duty_q;
  assign cmd_o.percent_value = pct_q;

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !cmd_o.ready |=> valid_q && $stable(duty_q) && $stable(pct_q))
    else $error("result changed while stalled");

  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && free_o |=> valid_q) else $error("loaded result lost");

  a_action_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (action_q == ACT_LEVEL || pct_q == 7'd0))
    else $error("percent set on on/off command");

endmodule

@@ rtl/core/uart_line_command_to_duty.sv @@
// Top level: input byte register, line decoder and command result register.
// Depends on ulcd_pkg, ulcd_if, ulcd_decoder and ulcd_out_stage.
//
// Usage:
//   rx_i carries received ASCII bytes; a transfer happens when valid and ready
//   are both high. cmd_o carries one command per accepted non-empty line that
//   decodes as ON, OFF or a percent 0..100; other lines produce nothing.
//   Line feed or carriage return ends a line; bytes past 15 per line are dropped.
//   Throughput: one byte per cycle, except while a terminator that produces a
//   command waits for the result register. Each byte is held in an input
//   register while the decoder updates the line state; the decode and the
//   duty multiply sit between that register and the result register.
//   A terminator's command is registered in the result register driving cmd_o.
//   Stall: while cmd_o is held, bytes that produce no command keep flowing;
//   a terminator that produces a command waits in the input register, and
//   rx_i.ready drops until the result register frees.
//   Reset: clears the line state and the valid flags of the input and result
//   registers; the block accepts bytes in the first cycle after reset.
module uart_line_command_to_duty (
  input  logic       clk_i,
  input  logic       rst_ni,
  ulcd_byte_if.sink  rx_i,
  ulcd_cmd_if.source cmd_o
);
  import ulcd_pkg::*;

  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       out_free;
  logic       adv;
  ulcd_res_t  res;

  assign adv        = in_v_q && (!res.hit || out_free);
  assign rx_i.ready = !in_v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_v_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  ulcd_decoder u_decoder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  ulcd_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (adv && res.hit),
    .res_i  (res),
    .free_o (out_free),
    .cmd_o  (cmd_o)
  );

endmodule

@@ tb/tb_uart_line_command_to_duty.sv @@
// Testbench for uart_line_command_to_duty: directed and random text lines in, duty commands checked.
// Depends on ulcd_pkg, ulcd_byte_if, ulcd_cmd_if and uart_line_command_to_duty.
`timescale 1ns / 100ps

module tb_uart_line_command_to_duty;
  import ulcd_pkg::*;

  localparam int unsigned RandBytes   = 1700;
  localparam int unsigned NumPhases   = 4;
  localparam int unsigned WatchLimit  = 5000;
  localparam int unsigned DrainCycles = 8;

  typedef struct packed {
    ulcd_action_e action;
    logic [7:0]   duty;
    logic [6:0]   percent;
  } duty_cmd_t;

  class duty_cmd_board;
    duty_cmd_t    expected_cmds[$];
    int unsigned  errors;
    int unsigned  line_len;
    ulcd_match_e  word_st;
    bit           digits_only;
    int unsigned  num_val;

    function new();
      errors = 0;
      clear_line();
    endfunction

    function void clear_line();
      line_len    = 0;
      word_st     = WM_START;
      digits_only = 1'b1;
      num_val     = 0;
    endfunction

    function void take_byte(logic [7:0] b);
      int unsigned v;
      if (b == ChrLf || b == ChrCr) begin
        if (line_len == 0) return;
        if (word_st == WM_ON) begin
          expected_cmds.push_back('{ACT_ON, DutyFull, 7'd0});
        end else if (word_st == WM_OFF) begin
          expected_cmds.push_back('{ACT_OFF, DutyOff, 7'd0});
        end else if (digits_only && num_val <= 100) begin
          expected_cmds.push_back('{ACT_LEVEL, 8'((num_val * 255) / 100), 7'(num_val)});
        end
        clear_line();
        return;
      end
      if (line_len >= MaxLine) return;
      line_len++;
      case (word_st)
        WM_START: word_st = (b == ChrO) ? WM_O : WM_NONE;
        WM_O: begin
          if (b == ChrN) word_st = WM_ON;
          else if (b == ChrF) word_st = WM_OF;
          else word_st = WM_NONE;
        end
        WM_OF:    word_st = (b == ChrF) ? WM_OFF : WM_NONE;
        default:  word_st = WM_NONE;
      endcase
      if (b >= ChrZero && b <= ChrNine) begin
        if (digits_only) begin
          v = num_val * 10 + int'(b - ChrZero);
          num_val = (v > 100) ? 101 : v;
        end
      end else begin
        digits_only = 1'b0;
      end
    endfunction

    function void check_cmd(logic [1:0] action, logic [7:0] duty, logic [6:0] percent);
      duty_cmd_t exp_cmd;
      if (expected_cmds.size() == 0) begin
        $error("unexpected command: action %0d duty_value %0d percent_value %0d",
               action, duty, percent);
        errors++;
        return;
      end
      exp_cmd = expected_cmds.pop_front();
      if (action !== exp_cmd.action) begin
        $error("action: expected %0d, actual %0d", exp_cmd.action, action);
        errors++;
      end
      if (duty !== exp_cmd.duty) begin
        $error("duty_value: expected %0d, actual %0d", exp_cmd.duty, duty);
        errors++;
      end
      if (percent !== exp_cmd.percent) begin
        $error("percent_value: expected %0d, actual %0d", exp_cmd.percent, percent);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ulcd_byte_if rx_if ();
  ulcd_cmd_if  cmd_if ();

  uart_line_command_to_duty dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .rx_i  (rx_if),
    .cmd_o (cmd_if)
  );

  duty_cmd_board board = new();
  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   sent_bytes     = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] rand_char();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == ChrLf || b == ChrCr);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    board.take_byte(b);
    sent_bytes++;
  endtask

  task automatic send_line(input string txt, input logic [7:0] term);
    for (int i = 0; i < txt.len(); i++) send_byte(txt[i]);
    send_byte(term);
  endtask

  task automatic send_random_line();
    logic [7:0]  chars[$];
    string       txt;
    int unsigned kind, pad, val, pos;
    logic [7:0]  term;
    string       alphabet;
    alphabet = "0123456789ONF";
    kind = $urandom_range(99);
    term = $urandom_range(1) ? ChrLf : ChrCr;
    txt  = "";
    if (kind < 25) begin
      txt = $urandom_range(1) ? "ON" : "OFF";
    end else if (kind < 72) begin
      if (kind < 60) val = $urandom_range(100);
      else if ($urandom_range(1)) val = $urandom_range(130, 101);
      else val = $urandom_range(32'hFFFF_FFFF, 131);
      pad = ($urandom_range(9) < 8) ? $urandom_range(2) : $urandom_range(15);
      repeat (pad) txt = {txt, "0"};
      txt = {txt, $sformatf("%0d", val)};
    end else if (kind < 84) begin
      if ($urandom_range(3) == 0) begin
        txt = $urandom_range(1) ? "ON" : "OFF";
      end else begin
        txt = $sformatf("%0d", $urandom_range(100));
        while (txt.len() < MaxLine) txt = {"0", txt};
      end
    end
    for (int i = 0; i < txt.len(); i++) chars.push_back(txt[i]);
    if (kind >= 15 && kind < 25) begin
      pos = $urandom_range(chars.size() - 1);
      case ($urandom_range(2))
        0: chars.pop_back();
        1: chars.insert(pos, rand_char());
        default: chars[pos] = rand_char();
      endcase
    end else if (kind >= 72 && kind < 84) begin
      repeat ($urandom_range(8, 1)) chars.push_back(rand_char());
    end else if (kind >= 84 && kind < 95) begin
      repeat ($urandom_range(18, 1)) begin
        if ($urandom_range(1)) chars.push_back(alphabet[$urandom_range(alphabet.len() - 1)]);
        else chars.push_back(rand_char());
      end
    end
    foreach (chars[i]) send_byte(chars[i]);
    send_byte(term);
    if ($urandom_range(4) == 0) send_byte((term == ChrLf) ? ChrCr : ChrLf);
  endtask

  initial begin
    cmd_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cmd_if.valid && cmd_if.ready) begin
        board.check_cmd(cmd_if.action, cmd_if.duty_value, cmd_if.percent_value);
      end
      cmd_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchLimit) begin
      @(posedge clk);
      if ((rx_if.valid && rx_if.ready) || (cmd_if.valid && cmd_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("uart_line_command_to_duty test failed");
    $finish;
  end

  initial begin
    int unsigned phase_end;
    rst_n         <= 1'b0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_line("ON", ChrLf);
    send_line("OFF", ChrCr);
    send_line("100", ChrLf);
    send_line("0", ChrCr);
    send_byte(ChrLf);
    send_line("101", ChrLf);
    send_byte(8'h00);
    send_byte(ChrLf);
    send_byte(8'hFF);
    send_byte(ChrCr);

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      phase_end = sent_bytes + RandBytes / NumPhases;
      while (sent_bytes < phase_end) send_random_line();
    end
    rx_if.valid <= 1'b0;

    while (board.expected_cmds.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (board.errors == 0) begin
      $display("uart_line_command_to_duty test passed");
    end else begin
      $display("uart_line_command_to_duty test failed");
    end
    $finish;
  end

endmodule
